### rtl/core/hps_pkg.sv
// Shared definitions for the hash partition scatter unit.
// Holds sizing constants, command and status codes, and controller types.
// No dependencies.
`default_nettype none

package hps_pkg;

  localparam int BUCKETS  = 16;
  localparam int MAX_KEYS = 65536;

  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int CW      = $clog2(MAX_KEYS + 1);
  localparam int KEY_W   = 31;
  localparam int SEL_W   = 4;
  localparam int POS_W   = 16;
  localparam int OCNT_W  = 17;
  localparam int STAT_W  = 2;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_COUNT = 2'd1,
    CMD_PLACE = 2'd2,
    CMD_READ  = 2'd3
  } command_t;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CAPACITY = 2'd1,
    STATUS_OVERRUN  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load_req;
    logic form_offsets;
    logic execute;
  } dp_ctrl_t;

  typedef struct packed {
    logic need_prep;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/hash_partition_scatter_unit.sv
// Top level of the hash partition scatter unit.
// Instantiates hps_controller and hps_datapath; depends on hps_pkg.
`default_nettype none

// Partition step of a hash join over 16 buckets (bucket = key mod 16). Count
// requests tally keys per bucket, place requests return each key's bucket and
// stable destination index, read requests report a bucket's count and end
// offset, and clear empties all bucket state. Each request is accepted into the
// request register and then executed by one read-modify-write of the per-bucket
// registers that loads the result register. The first place after any count
// first passes through an offset-forming step, in which all bucket start slots
// are formed at once from the running end offsets. A result held by out_stall
// delays the next request only after the following one has been accepted.
module hash_partition_scatter_unit
  import hps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        command,
  input  wire logic [KEY_W-1:0]  key,
  input  wire logic [SEL_W-1:0]  bucket_select,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [SEL_W-1:0]       bucket,
  output logic [POS_W-1:0]       position,
  output logic [OCNT_W-1:0]      bucket_count,
  output logic [OCNT_W-1:0]      bucket_end,
  output logic [STAT_W-1:0]      status
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  hps_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  hps_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .stat          (stat),
    .command       (command),
    .key           (key),
    .bucket_select (bucket_select),
    .bucket        (bucket),
    .position      (position),
    .bucket_count  (bucket_count),
    .bucket_end    (bucket_end),
    .status        (status)
  );

endmodule

`default_nettype wire

### rtl/core/hps_datapath.sv
// Datapath of the hash partition scatter unit: bucket counts, end offsets,
// next free slots, the latched request and the result register.
// Depends on hps_pkg.
`default_nettype none

module hps_datapath
  import hps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dp_ctrl_t          ctrl,
  output dp_stat_t               stat,
  input  wire logic [1:0]        command,
  input  wire logic [KEY_W-1:0]  key,
  input  wire logic [SEL_W-1:0]  bucket_select,
  output logic [SEL_W-1:0]       bucket,
  output logic [POS_W-1:0]       position,
  output logic [OCNT_W-1:0]      bucket_count,
  output logic [OCNT_W-1:0]      bucket_end,
  output logic [STAT_W-1:0]      status
);

  command_t         req_cmd;
  logic [KEY_W-1:0] req_key;
  logic [SEL_W-1:0] req_sel;

  logic [CW-1:0] counts    [BUCKETS];
  logic [CW-1:0] ends      [BUCKETS];
  logic [CW-1:0] next_free [BUCKETS];
  logic          offsets_ready;
  logic [CW-1:0] key_total;

  logic [BKT_W-1:0] idx;
  logic             sel_ok;
  logic             at_cap;
  logic             overrun;

  logic [SEL_W-1:0]  r_bucket;
  logic [POS_W-1:0]  r_pos;
  logic [OCNT_W-1:0] r_cnt;
  logic [OCNT_W-1:0] r_end;
  status_t           r_status;

  // The bucket count is a power of two, so key mod BUCKETS is the low bits.
  // A read drives the same index idx from the selected bucket.
  always_comb begin
    if (req_cmd == CMD_READ) begin
      idx = BKT_W'(req_sel);
    end else begin
      idx = req_key[BKT_W-1:0];
    end
    sel_ok  = int'(req_sel) < BUCKETS;
    at_cap  = key_total >= CW'(MAX_KEYS);
    overrun = next_free[idx] >= ends[idx];
  end

  assign stat.need_prep = (req_cmd == CMD_PLACE) && !offsets_ready;

  always_comb begin
    r_bucket = '0;
    r_pos    = '0;
    r_cnt    = '0;
    r_end    = '0;
    r_status = STATUS_OK;
    unique case (req_cmd)
      CMD_CLEAR: begin
      end
      CMD_COUNT: begin
        r_bucket = SEL_W'(idx);
        if (at_cap) begin
          r_status = STATUS_CAPACITY;
          r_cnt    = OCNT_W'(counts[idx]);
        end else begin
          r_cnt = OCNT_W'(counts[idx] + CW'(1));
        end
      end
      CMD_PLACE: begin
        r_bucket = SEL_W'(idx);
        r_cnt    = OCNT_W'(counts[idx]);
        r_end    = OCNT_W'(ends[idx]);
        if (overrun) begin
          r_status = STATUS_OVERRUN;
        end else begin
          r_pos = POS_W'(next_free[idx]);
        end
      end
      CMD_READ: begin
        r_bucket = req_sel;
        if (sel_ok) begin
          r_cnt = OCNT_W'(counts[idx]);
          r_end = OCNT_W'(ends[idx]);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_cmd <= CMD_CLEAR;
    end else if (ctrl.load_req) begin
      req_cmd <= command_t'(command);
      req_key <= key;
      req_sel <= bucket_select;
    end
    if (ctrl.execute) begin
      bucket       <= r_bucket;
      position     <= r_pos;
      bucket_count <= r_cnt;
      bucket_end   <= r_end;
      status       <= STAT_W'(r_status);
    end
  end

  // ends[i] always holds the inclusive prefix sum of counts 0..i, kept up
  // to date on every count so that no walk over the buckets is needed.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUCKETS; i++) begin
        counts[i]    <= '0;
        ends[i]      <= '0;
        next_free[i] <= '0;
      end
      offsets_ready <= 1'b0;
      key_total     <= '0;
    end else begin
      if (ctrl.form_offsets) begin
        for (int i = 0; i < BUCKETS; i++) begin
          next_free[i] <= ends[i] - counts[i];
        end
        offsets_ready <= 1'b1;
      end
      if (ctrl.execute) begin
        unique case (req_cmd)
          CMD_CLEAR: begin
            for (int i = 0; i < BUCKETS; i++) begin
              counts[i]    <= '0;
              ends[i]      <= '0;
              next_free[i] <= '0;
            end
            offsets_ready <= 1'b0;
            key_total     <= '0;
          end
          CMD_COUNT: begin
            if (!at_cap) begin
              counts[idx] <= counts[idx] + CW'(1);
              for (int i = 0; i < BUCKETS; i++) begin
                if (i >= int'(idx)) begin
                  ends[i] <= ends[i] + CW'(1);
                end
              end
              key_total     <= key_total + CW'(1);
              offsets_ready <= 1'b0;
            end
          end
          CMD_PLACE: begin
            if (!overrun) begin
              next_free[idx] <= next_free[idx] + CW'(1);
            end
          end
          CMD_READ: begin
          end
        endcase
      end
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    key_total <= CW'(MAX_KEYS))
    else $error("key total exceeds capacity");

  a_last_end: assert property (@(posedge clk) disable iff (rst)
    ends[BUCKETS-1] == key_total)
    else $error("last bucket end differs from key total");

  a_prep_done: assert property (@(posedge clk) disable iff (rst)
    ctrl.form_offsets |=> offsets_ready && !stat.need_prep)
    else $error("offsets not ready after formation");

endmodule

`default_nettype wire

### rtl/core/hps_controller.sv
// Controller of the hash partition scatter unit: request intake, offset
// formation and result hand-off. Depends on hps_pkg.
`default_nettype none

module hps_controller
  import hps_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output dp_ctrl_t      ctrl,
  input  wire dp_stat_t stat
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ctrl.load_req = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // A place after new counts first rebuilds the start slots.
        if (stat.need_prep) begin
          ctrl.form_offsets = 1'b1;
        end else if (!out_valid || !out_stall) begin
          ctrl.execute = 1'b1;
          state_next   = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    priority if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.execute) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one still in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.execute |-> !(out_valid && out_stall))
    else $error("result register overwritten while held");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    ctrl.execute |=> out_valid)
    else $error("executed request produced no result");

endmodule

`default_nettype wire
